// ===== hdl/sliding_median_with_flags_core_macros.svh =====
// Assertion macros for the sliding median core.
// Used by sliding_median_with_flags_core; clock aclk, reset aresetn.
`ifndef SLIDING_MEDIAN_WITH_FLAGS_CORE_MACROS_SVH
`define SLIDING_MEDIAN_WITH_FLAGS_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SMF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sliding median check failed");

// Condition that must hold on every clock out of reset
`define SMF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("sliding median check failed");

`endif

// ===== hdl/smf_pkg.sv =====
// Shared constants and types for the sliding median core.
// No dependencies.
package smf_pkg;

    localparam int SAMPLE_W        = 32;  // signed Q16.16 sample
    localparam int COUNT_W         = 5;   // reported valid count width
    localparam int HALF_WINDOW_DEF = 8;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } smf_state_t;

endpackage

// ===== hdl/sliding_median_with_flags_core.sv =====
// Sliding-window median over 2*HALF_WINDOW+1 samples with per-sample invalid flags.
// Depends on smf_pkg and sliding_median_with_flags_core_macros.svh.
//
// One input beat yields one result beat: the median of the valid samples in the
// window (value at sorted position count/2, 0 when none), their count, and a
// median-valid bit. The sorted list of valid samples (value plus ring slot) lives
// in a ping-pong list memory with a registered read. Each beat walks the old
// list through the single read port, dropping the outgoing slot and merging the
// incoming sample, while writing the new list into the other bank; the median is
// captured as it is written. The walk reads one old entry per cycle, holding the
// read while a mid-list insertion of the new sample is written. The finished
// result sits in an output register, so the next beat is accepted while it
// waits. No clearing pass is needed after reset.
module sliding_median_with_flags_core #(
    parameter int HALF_WINDOW = smf_pkg::HALF_WINDOW_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [smf_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                                  s_flagged,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [smf_pkg::SAMPLE_W-1:0]   m_median,
    output logic        [smf_pkg::COUNT_W-1:0]    m_valid_count,
    output logic                                  m_median_valid
);
    import smf_pkg::*;

    localparam int WIN_LEN   = 2 * HALF_WINDOW + 1;
    localparam int IDX_W     = $clog2(WIN_LEN);
    localparam int CNT_W     = $clog2(WIN_LEN + 1);
    localparam int MEM_DEPTH = 1 << (IDX_W + 1);

    typedef struct packed {
        logic        [IDX_W-1:0]    slot;
        logic signed [SAMPLE_W-1:0] value;
    } entry_t;

    // control state
    smf_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]           write_slot_reg;
    logic [WIN_LEN-1:0]         slot_valid_reg;
    logic [CNT_W-1:0]           valid_total_reg;
    logic                       bank_reg;
    logic                       ins_pend_reg;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]           wr_ptr_reg;
    logic                       m_valid_reg;

    // payload state
    logic [IDX_W-1:0]           cur_slot_reg;
    logic signed [SAMPLE_W-1:0] din_reg;
    logic [CNT_W-1:0]           new_total_reg;
    logic signed [SAMPLE_W-1:0] med_reg;
    logic signed [SAMPLE_W-1:0] m_median_reg;
    logic [COUNT_W-1:0]         m_valid_count_reg;
    logic                       m_median_valid_reg;

    // list memory, two banks of sorted entries
    entry_t                     list_mem [MEM_DEPTH];
    entry_t                     rd_data_reg;
    logic [IDX_W:0]             rd_addr, wr_addr;

    // datapath controls
    logic                       accept;
    logic                       exhausted;
    logic                       rd_hit;
    logic                       ins_here;
    logic                       wr_en;
    entry_t                     wr_data;
    logic                       advance;
    logic                       ins_take;
    logic                       out_load;
    logic                       vout;
    logic                       vin;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign vout           = slot_valid_reg[write_slot_reg];
    assign vin            = !s_flagged;
    assign exhausted      = (rd_idx_reg == valid_total_reg);
    assign rd_hit         = (rd_data_reg.slot == cur_slot_reg);
    assign ins_here       = ins_pend_reg && (rd_data_reg.value >= din_reg);

    assign m_valid        = m_valid_reg;
    assign m_median       = m_median_reg;
    assign m_valid_count  = m_valid_count_reg;
    assign m_median_valid = m_median_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (exhausted) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // merge walk: drop outgoing slot, insert new sample ahead of equal values
    always_comb begin
        wr_en    = 1'b0;
        wr_data  = '{slot: cur_slot_reg, value: din_reg};
        advance  = 1'b0;
        ins_take = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
            end
            ST_WALK: begin
                if (exhausted) begin
                    if (ins_pend_reg) begin
                        wr_en    = 1'b1;
                        ins_take = 1'b1;
                    end
                end else if (rd_hit) begin
                    advance = 1'b1;
                end else if (ins_here) begin
                    wr_en    = 1'b1;
                    ins_take = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                    advance = 1'b1;
                end
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // read pointer: held at list head outside the walk
    always_comb begin
        if (state_reg == ST_WALK) begin
            rd_idx_next = rd_idx_reg + CNT_W'(advance);
        end else begin
            rd_idx_next = '0;
        end
    end

    assign rd_addr = {bank_reg, rd_idx_next[IDX_W-1:0]};
    assign wr_addr = {~bank_reg, wr_ptr_reg[IDX_W-1:0]};

    // list memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            list_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            slot_valid_reg  <= '0;
            valid_total_reg <= '0;
            bank_reg        <= 1'b0;
            ins_pend_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            wr_ptr_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            if (accept) begin
                slot_valid_reg[write_slot_reg] <= vin;
                ins_pend_reg                   <= vin;
                wr_ptr_reg                     <= '0;
                if (write_slot_reg == IDX_W'(WIN_LEN - 1)) begin
                    write_slot_reg <= '0;
                end else begin
                    write_slot_reg <= write_slot_reg + 1'b1;
                end
            end else begin
                if (ins_take) begin
                    ins_pend_reg <= 1'b0;
                end
                if (wr_en) begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (out_load) begin
                bank_reg        <= ~bank_reg;
                valid_total_reg <= new_total_reg;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_slot_reg  <= write_slot_reg;
            din_reg       <= s_sample;
            new_total_reg <= valid_total_reg - CNT_W'(vout) + CNT_W'(vin);
            med_reg       <= '0;
        end else if (wr_en && (wr_ptr_reg == (new_total_reg >> 1))) begin
            med_reg <= wr_data.value;
        end
        if (out_load) begin
            m_median_reg       <= med_reg;
            m_valid_count_reg  <= COUNT_W'(new_total_reg);
            m_median_valid_reg <= (new_total_reg != '0);
        end
    end

`include "sliding_median_with_flags_core_macros.svh"

    `SMF_ASSERT_ALWAYS(a_total_bound, valid_total_reg <= CNT_W'(WIN_LEN))
    `SMF_ASSERT_IMPL(a_wr_in_range, wr_en, wr_ptr_reg < new_total_reg)
    `SMF_ASSERT_IMPL(a_count_matches, state_reg == ST_IDLE,
                     $countones(slot_valid_reg) == int'(valid_total_reg))
    `SMF_ASSERT_IMPL(a_insert_done, state_reg == ST_FINISH, !ins_pend_reg)

endmodule

// ===== dv/tb_sliding_median_with_flags_core.sv =====
// Self-checking testbench for sliding_median_with_flags_core: directed table, then random beats.
// Depends on smf_pkg and the core RTL; a behavioral window model predicts every result beat not typed in the table.
module tb_sliding_median_with_flags_core;
    import smf_pkg::*;

    localparam int WIN_LEN       = 2 * HALF_WINDOW_DEF + 1;
    localparam int RANDOM_ITEMS  = 1928;
    localparam int PHASE_COUNT   = 4;
    localparam int SETTLE_CYCLES = 2 * WIN_LEN;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic [COUNT_W-1:0]         count;
        logic                       med_valid;
    } median_result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       flagged;
        logic                       typed;
        median_result_t             result;
    } stim_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_flagged;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_median;
    logic [COUNT_W-1:0]         m_valid_count;
    logic                       m_median_valid;

    // window model state
    logic signed [SAMPLE_W-1:0] ring_value [WIN_LEN];
    logic                       ring_ok [WIN_LEN];
    int                         wr_slot;

    median_result_t median_expected_q [$];
    stim_row_t      directed_rows [$];
    int             error_count = 0;
    int             cycle_count = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;

    sliding_median_with_flags_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_flagged      (s_flagged),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median),
        .m_valid_count  (m_valid_count),
        .m_median_valid (m_median_valid)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Advance the window by one sample and return the median of the valid samples.
    // Recomputes the sorted order each time; ties are irrelevant since only values matter.
    function automatic median_result_t window_median_step(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       flg
    );
        logic signed [SAMPLE_W-1:0] vals [WIN_LEN];
        logic signed [SAMPLE_W-1:0] t;
        int             n;
        int             i;
        int             j;
        median_result_t r;
        ring_value[wr_slot] = smp;
        ring_ok[wr_slot] = !flg;
        wr_slot = (wr_slot == WIN_LEN - 1) ? 0 : wr_slot + 1;
        n = 0;
        for (i = 0; i < WIN_LEN; i++) begin
            if (ring_ok[i]) begin
                vals[n] = ring_value[i];
                n++;
            end
        end
        // insertion sort, signed compare
        for (i = 1; i < n; i++) begin
            t = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > t) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = t;
        end
        r.median    = (n > 0) ? vals[n / 2] : '0;
        r.count     = n[COUNT_W-1:0];
        r.med_valid = (n > 0);
        return r;
    endfunction

    function automatic void add_row(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       flg,
        input logic                       typed,
        input logic signed [SAMPLE_W-1:0] med,
        input int                         cnt,
        input logic                       mv
    );
        stim_row_t row;
        row.sample           = smp;
        row.flagged          = flg;
        row.typed            = typed;
        row.result.median    = med;
        row.result.count     = cnt[COUNT_W-1:0];
        row.result.med_valid = mv;
        directed_rows.push_back(row);
    endfunction

    // Drive one beat, wait for acceptance, then record what the window should report
    task automatic send_sample(input stim_row_t row);
        median_result_t predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= row.sample;
        s_flagged <= row.flagged;
        do @(posedge aclk); while (!s_ready);
        predicted = window_median_step(row.sample, row.flagged);
        median_expected_q.push_back(row.typed ? row.result : predicted);
    endtask

    // Random sample: mostly wide values, with clusters of equal values and extremes
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom;
        else if (sel < 70)
            return $signed($urandom_range(0, 8)) - 4;
        else if (sel < 85) begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                default: return 32'sh0000_0001;
            endcase
        end else
            return $signed({16'($urandom_range(0, 15)), 16'h0000}) - 32'sh0008_0000;
    endfunction

    // Result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        median_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (median_expected_q.size() == 0) begin
                $error("result beat with no expectation waiting: median %0d count %0d",
                       m_median, m_valid_count);
                error_count++;
            end else begin
                exp_r = median_expected_q.pop_front();
                if (m_median !== exp_r.median) begin
                    $error("median: expected %0d, got %0d", exp_r.median, m_median);
                    error_count++;
                end
                if (m_valid_count !== exp_r.count) begin
                    $error("valid_count: expected %0d, got %0d", exp_r.count, m_valid_count);
                    error_count++;
                end
                if (m_median_valid !== exp_r.med_valid) begin
                    $error("median_valid: expected %0d, got %0d",
                           exp_r.med_valid, m_median_valid);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        stim_row_t row;
        int        phase;
        int        k;
        int        flag_pct;
        s_valid   <= 1'b0;
        s_sample  <= '0;
        s_flagged <= 1'b0;
        for (k = 0; k < WIN_LEN; k++) begin
            ring_value[k] = '0;
            ring_ok[k]    = 1'b0;
        end
        wr_slot = 0;

        // Directed table; typed expectations only where obvious
        // empty window after reset
        add_row(32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh0, 0, 1'b0);
        add_row(32'sh0000_0000, 1'b1, 1'b1, 32'sh0, 0, 1'b0);
        // extremes
        add_row(32'sh8000_0000, 1'b0, 1'b1, 32'sh8000_0000, 1, 1'b1);
        add_row(32'sh7FFF_FFFF, 1'b0, 1'b1, 32'sh7FFF_FFFF, 2, 1'b1);
        add_row(32'sh0000_0000, 1'b0, 1'b1, 32'sh0000_0000, 3, 1'b1);
        add_row(32'sh0000_0000, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(-32'sd1,        1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh0000_0001, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(-32'sd1,        1'b1, 1'b0, '0, 0, 1'b0);
        add_row(32'sh0001_0000, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'shFFFF_0000, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh5555_5555, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'shAAAA_AAAA, 1'b1, 1'b0, '0, 0, 1'b0);
        add_row(32'shAAAA_AAAA, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh7FFF_FFFF, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh8000_0000, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh0000_8000, 1'b0, 1'b0, '0, 0, 1'b0);
        // wrapped: flagged slot gets a valid sample (insert only)
        add_row(32'sh0000_0002, 1'b0, 1'b0, '0, 0, 1'b0);
        // flagged replaces flagged
        add_row(32'sh1234_5678, 1'b1, 1'b0, '0, 0, 1'b0);
        // valid replaces equal valid, list untouched
        add_row(32'sh8000_0000, 1'b0, 1'b0, '0, 0, 1'b0);
        // flagged replaces valid (remove only)
        add_row(32'sh7FFF_FFFF, 1'b1, 1'b0, '0, 0, 1'b0);
        // valid replaces different valid (move)
        add_row(32'sh1234_5678, 1'b0, 1'b0, '0, 0, 1'b0);
        add_row(32'sh0000_0000, 1'b0, 1'b0, '0, 0, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i]);

        // Random phases: none, sender idle, receiver stall, both
        flag_pct = 0;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            // drain fully before changing the idle pattern
            s_valid <= 1'b0;
            while (median_expected_q.size() != 0)
                @(posedge aclk);
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            for (k = 0; k < RANDOM_ITEMS / PHASE_COUNT; k++) begin
                // new flag density every 40 beats: full, sparse, empty windows
                if (k % 40 == 0) begin
                    case ($urandom_range(0, 5))
                        0, 1: flag_pct = 0;
                        2:    flag_pct = 10;
                        3:    flag_pct = 50;
                        4:    flag_pct = 85;
                        default: flag_pct = 100;
                    endcase
                end
                row.sample  = pick_sample();
                row.flagged = ($urandom_range(0, 99) < flag_pct);
                row.typed   = 1'b0;
                row.result  = '0;
                send_sample(row);
            end
        end
        s_valid <= 1'b0;

        // Wind down
        while (median_expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
